### design/kre_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lane functions of the Keccak round engine.
// No dependencies; used by kre_round and keccak_round_engine_core.
package kre_pkg;

  localparam int LANE_MAX = 64;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_ROUND = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef logic [LANE_MAX-1:0] lane_t;
  typedef lane_t [4:0][4:0] kstate_t;      // [x][y]
  typedef logic [4:0][4:0][5:0] rho_tbl_t;
  typedef logic [255:0][6:0] rc_tbl_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  lane_x;
    logic [2:0]  lane_y;
    lane_t       lane_data;
    logic [7:0]  round_index;
  } req_t;

  function automatic logic [254:0] build_rc_seq();
    logic [254:0] seq;
    logic [8:0]   r;
    r = 9'd1;
    for (int t = 0; t < 255; t++) begin
      seq[t] = r[0];
      r = r << 1;
      if (r[8]) r = r ^ 9'h171;
    end
    return seq;
  endfunction

  localparam logic [254:0] RC_SEQ = build_rc_seq();

  function automatic rc_tbl_t build_rc_tbl();
    rc_tbl_t tbl;
    for (int ri = 0; ri < 256; ri++)
      for (int j = 0; j < 7; j++)
        tbl[ri][j] = RC_SEQ[(j + 7 * ri) % 255];
    return tbl;
  endfunction

  localparam rc_tbl_t RC_TBL = build_rc_tbl();

  function automatic rho_tbl_t build_rho_tbl();
    rho_tbl_t tbl;
    int x, y, nx;
    tbl = '0;
    x = 1;
    y = 0;
    for (int t = 0; t < 24; t++) begin
      tbl[x][y] = 6'(((t + 1) * (t + 2) / 2) % LANE_MAX);
      nx = (2 * x + 3 * y) % 5;
      x = y;
      y = nx;
    end
    return tbl;
  endfunction

  localparam rho_tbl_t RHO_TBL = build_rho_tbl();

  function automatic lane_t lane_mask(input logic [2:0] l);
    lane_t m;
    m = '1;
    for (int k = 0; k < 6; k++)
      if (l == 3'(k)) m = (lane_t'(1) << (1 << k)) - lane_t'(1);
    return m;
  endfunction

  // rotate left within a lane of 2^l bits
  function automatic lane_t rotl_w(input lane_t v, input logic [5:0] n, input logic [2:0] l);
    lane_t m;
    lane_t r;
    lane_t o;
    logic [5:0] nn;
    m = lane_mask(l);
    r = v & m;
    o = r;
    for (int k = 0; k <= 6; k++) begin
      if (l == 3'(k)) begin
        nn = n & 6'((1 << k) - 1);
        if (nn != 6'd0) o = ((r << nn) | (r >> (7'(1 << k) - 7'(nn)))) & m;
      end
    end
    return o;
  endfunction

endpackage

### design/kre_round.sv
`timescale 1ns / 1ps
// One full Keccak-f round (theta, rho, pi, chi, iota) on a 5x5 lane state.
// Depends on kre_pkg for the state type, rotation and round-constant tables.
module kre_round import kre_pkg::*; (
  input  kstate_t    state_in,
  input  logic [2:0] lane_log2,
  input  logic [7:0] round_index,
  output kstate_t    state_out
);

  lane_t      m;
  lane_t      c [5];
  lane_t      d [5];
  kstate_t    a;
  kstate_t    r;
  kstate_t    b;
  kstate_t    x_chi;
  lane_t      rc_lane;
  logic [6:0] rc_bits;

  assign m       = lane_mask(lane_log2);
  assign rc_bits = RC_TBL[round_index];

  always_comb begin
    for (int x = 0; x < 5; x++)
      for (int y = 0; y < 5; y++)
        a[x][y] = state_in[x][y] & m;
    for (int x = 0; x < 5; x++)
      c[x] = a[x][0] ^ a[x][1] ^ a[x][2] ^ a[x][3] ^ a[x][4];
    for (int x = 0; x < 5; x++)
      d[x] = c[(x + 4) % 5] ^ rotl_w(c[(x + 1) % 5], 6'd1, lane_log2);
    for (int x = 0; x < 5; x++)
      for (int y = 0; y < 5; y++)
        r[x][y] = rotl_w(a[x][y] ^ d[x], RHO_TBL[x][y], lane_log2);
    for (int x = 0; x < 5; x++)
      for (int y = 0; y < 5; y++)
        b[x][y] = r[(x + 3 * y) % 5][x];
    for (int x = 0; x < 5; x++)
      for (int y = 0; y < 5; y++)
        x_chi[x][y] = b[x][y] ^ (~b[(x + 1) % 5][y] & b[(x + 2) % 5][y]);
  end

  always_comb begin
    rc_lane = '0;
    for (int j = 0; j < 7; j++)
      rc_lane[(1 << j) - 1] = rc_bits[j];
  end

  always_comb begin
    for (int x = 0; x < 5; x++)
      for (int y = 0; y < 5; y++)
        state_out[x][y] = x_chi[x][y] & m;
    state_out[0][0] = (x_chi[0][0] ^ rc_lane) & m;
  end

endmodule

### design/keccak_round_engine_core.sv
`timescale 1ns / 1ps
// Keccak-f round engine top level: request register, 5x5 lane registers, result register.
// Depends on kre_pkg and kre_round.
//
// Takes one request per clock unless the result side stalls and returns one result
// per request via the request register and then the result register. Each request
// writes a lane, reads a lane or applies one whole Keccak-f round, done combinationally
// by kre_round on all 25 lane registers at once, so back-to-back rounds run at one per
// clock unless the result side stalls. The lane width is 2^cfg_wdata bits, limited to
// LANE_BITS and to 64; write the width only while no request is in flight. The number
// of rounds and the round sequence are driven by the caller through round_index.
module keccak_round_engine_core import kre_pkg::*; #(
  parameter int LANE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // lane_x[2:0], lane_y[5:3], lane_data[69:6],
                                  // round_index[77:70], zero[79:78]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // lane_value[63:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata   // lane_log2
);

  localparam int         MAX_L  = $clog2(LANE_BITS + 1) - 1;
  localparam logic [2:0] MAX_L3 = 3'(MAX_L);

  logic [2:0]           lane_log2_r;
  req_t                 req_r;
  logic                 req_valid_r;
  logic                 req_valid_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [63:0]          out_data_r;
  logic [LANE_BITS-1:0] lane_r [5][5];

  logic       req_go;
  logic       exec;
  logic       in_accept;
  logic       lane_in_range;
  logic [2:0] eff_log2;
  lane_t      mask_w;
  lane_t      rd_value;
  kstate_t    st_cur;
  kstate_t    st_next;
  req_t       req_in;

  assign req_in.mode        = mode_t'(in_tuser);
  assign req_in.lane_x      = in_tdata[2:0];
  assign req_in.lane_y      = in_tdata[5:3];
  assign req_in.lane_data   = in_tdata[69:6];
  assign req_in.round_index = in_tdata[77:70];

  assign req_go    = !out_valid_r || out_tready;
  assign in_tready = !req_valid_r || req_go;
  assign in_accept = in_tvalid && in_tready;
  assign exec      = req_valid_r && req_go;

  assign eff_log2      = (lane_log2_r > MAX_L3) ? MAX_L3 : lane_log2_r;
  assign mask_w        = lane_mask(eff_log2);
  assign lane_in_range = (req_r.lane_x < 3'd5) && (req_r.lane_y < 3'd5);
  assign rd_value      = lane_in_range ?
                         (lane_t'(lane_r[req_r.lane_x][req_r.lane_y]) & mask_w) : '0;

  always_comb begin
    for (int x = 0; x < 5; x++)
      for (int y = 0; y < 5; y++)
        st_cur[x][y] = lane_t'(lane_r[x][y]);
  end

  kre_round u_round (
    .state_in    (st_cur),
    .lane_log2   (eff_log2),
    .round_index (req_r.round_index),
    .state_out   (st_next)
  );

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (in_accept) req_valid_nxt = 1'b1;
    else if (req_go) req_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (exec) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      lane_log2_r <= 3'd6;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) lane_log2_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) req_r <= req_in;
    if (exec) out_data_r <= (req_r.mode == MODE_READ) ? rd_value : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int x = 0; x < 5; x++)
        for (int y = 0; y < 5; y++)
          lane_r[x][y] <= '0;
    end else if (exec) begin
      unique case (req_r.mode)
        MODE_WRITE: begin
          if (lane_in_range)
            lane_r[req_r.lane_x][req_r.lane_y] <=
              req_r.lane_data[LANE_BITS-1:0] & mask_w[LANE_BITS-1:0];
        end
        MODE_ROUND: begin
          for (int x = 0; x < 5; x++)
            for (int y = 0; y < 5; y++)
              lane_r[x][y] <= st_next[x][y][LANE_BITS-1:0];
        end
        MODE_READ, MODE_NOP: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### design/kre_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the Keccak round engine, bound to keccak_round_engine_core.
// No dependencies beyond the top level's ports.
module kre_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("request refused while result side is free");

  a_two_cycle_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("accepted request produced no result");

endmodule

bind keccak_round_engine_core kre_checker u_kre_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
